// File: rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and codes of the relay command supervisor.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_ACK    = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RELAY = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_UNKNOWN   = 4'd1;
  localparam logic [3:0] EV_DETECTED  = 4'd2;
  localparam logic [3:0] EV_CONFIRMED = 4'd3;
  localparam logic [3:0] EV_CHANGED   = 4'd4;
  localparam logic [3:0] EV_SILENT    = 4'd5;
  localparam logic [3:0] EV_PULSE_END = 4'd6;
  localparam logic [3:0] EV_RETRY     = 4'd7;
  localparam logic [3:0] EV_TIMEOUT   = 4'd8;

  localparam logic [2:0] REG_OUTLET_COUNT     = 3'd0;
  localparam logic [2:0] REG_RETRY_PERIOD     = 3'd1;
  localparam logic [2:0] REG_CONFIRM_WINDOW   = 3'd2;
  localparam logic [2:0] REG_QUERY_PERIOD     = 3'd3;
  localparam logic [2:0] REG_BROADCAST_PERIOD = 3'd4;
  localparam logic [2:0] REG_SILENCE_LIMIT    = 3'd5;

  typedef enum logic [2:0] {
    K_NONE, K_UNKNOWN, K_SET, K_REPORT, K_ACK, K_TICK
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  outlet;
    logic        req_state;
    logic [15:0] pulse_seconds;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       broadcast;
    logic [3:0] target;
    logic       drive_state;
    logic [3:0] event_res;
  } result_t;

  typedef struct packed {
    logic [4:0]  active;
    logic [7:0]  retry_period;
    logic [7:0]  confirm_window;
    logic [15:0] query_period;
    logic [15:0] broadcast_period;
    logic [15:0] silence_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE, B_TICK, B_PASS, B_QRY, B_SIL, B_PUL, B_CMP,
    B_SET, B_REP1, B_REP2, B_ACK, B_UNK, B_END
  } bstate_t;

endpackage

// File: rtl/rcs_front.sv
// ----------------------------------------------------------------------------
// rcs_front
// Classifies an accepted request into the kind of work the back end runs.
// ----------------------------------------------------------------------------
module rcs_front (
  input  logic             start,
  input  logic [1:0]       opcode,
  input  logic [3:0]       outlet,
  input  logic             req_state,
  input  logic [15:0]      pulse_seconds,
  input  logic             ack_error,
  input  logic [4:0]       active,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output rcs_pkg::item_t   item
);
  import rcs_pkg::*;

  kind_t kind;

  always_comb begin
    unique case (opcode)
      OP_TICK:   kind = K_TICK;
      OP_SET:    kind = K_SET;
      OP_REPORT: kind = K_REPORT;
      default:   kind = ack_error ? K_NONE : K_ACK;
    endcase
    if (kind != K_TICK && kind != K_NONE && {1'b0, outlet} >= active) begin
      kind = K_UNKNOWN;
    end
  end

  assign busy = q_full;
  assign push = start && !q_full;
  assign item = '{kind: kind, outlet: outlet, req_state: req_state,
                  pulse_seconds: pulse_seconds};

endmodule

// File: rtl/rcs_queue.sv
// ----------------------------------------------------------------------------
// rcs_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module rcs_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rcs_pkg::item_t  wr_item,
  input  logic            pop,
  output rcs_pkg::item_t  rd_item,
  output logic            empty,
  output logic            full
);
  import rcs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// File: rtl/rcs_back.sv
// ----------------------------------------------------------------------------
// rcs_back
// Sequencer that carries out one request at a time on the outlet table.
// ----------------------------------------------------------------------------
module rcs_back #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  rcs_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  rcs_pkg::item_t    q_item,
  output logic              pop,
  output logic              res_valid,
  output rcs_pkg::result_t  res,
  output logic              res_last
);
  import rcs_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  bstate_t state, state_next;
  item_t   it;
  logic [IW-1:0] ptr;

  logic [31:0] seconds_now, last_bc, last_pass;
  logic        rs [SLOTS];
  logic        cs [SLOTS];
  logic        ak [SLOTS];
  logic [31:0] cd [SLOTS];
  logic [31:0] pe [SLOTS];
  logic [31:0] lq [SLOTS];
  logic [31:0] ls [SLOTS];

  logic        hold_v;
  result_t     hold;
  logic        emit;
  result_t     emit_r;

  logic [31:0] now1;
  logic        c_bc, c_pass, c_qry, c_sil, c_pul, c_mis, c_live, c_lastp;
  logic        c_conf;

  always_comb begin
    now1    = seconds_now + 32'd1;
    c_bc    = {1'b0, now1} >= ({1'b0, last_bc} + 33'(cfg.broadcast_period));
    c_pass  = {1'b0, seconds_now} >= ({1'b0, last_pass} + 33'(cfg.retry_period));
    c_qry   = {1'b0, seconds_now} >= ({1'b0, lq[ptr]} + 33'(cfg.query_period));
    c_sil   = (ls[ptr] != '0) &&
              (({1'b0, ls[ptr]} + 33'(cfg.silence_limit)) < {1'b0, seconds_now});
    c_pul   = (pe[ptr] != '0) && (seconds_now >= pe[ptr]);
    c_mis   = (rs[ptr] != cs[ptr]);
    c_live  = (cd[ptr] > seconds_now);
    c_lastp = ((5'(ptr) + 5'd1) >= cfg.active);
    c_conf  = (cd[ptr] != '0) && (it.req_state == cs[ptr]);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (q_item.kind)
            K_TICK:    state_next = B_TICK;
            K_SET:     state_next = B_SET;
            K_REPORT:  state_next = B_REP1;
            K_ACK:     state_next = B_ACK;
            K_UNKNOWN: state_next = B_UNK;
            default:   state_next = B_END;
          endcase
        end
      end
      B_TICK: state_next = B_PASS;
      B_PASS: state_next = (c_pass && cfg.active != '0) ? B_QRY : B_END;
      B_QRY:  state_next = B_SIL;
      B_SIL:  state_next = B_PUL;
      B_PUL:  state_next = B_CMP;
      B_CMP:  state_next = c_lastp ? B_END : B_QRY;
      B_REP1: state_next = B_REP2;
      B_SET, B_REP2, B_ACK, B_UNK: state_next = B_END;
      B_END:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs of each step: queue pop and the result it produces.
  always_comb begin
    pop    = 1'b0;
    emit   = 1'b0;
    emit_r = '{action: ACT_NONE, broadcast: 1'b0, target: 4'(ptr),
               drive_state: 1'b0, event_res: EV_NONE};
    unique case (state)
      B_IDLE: pop = !q_empty;
      B_TICK: begin
        if (c_bc) begin
          emit = 1'b1;
          emit_r.action    = ACT_QUERY;
          emit_r.broadcast = 1'b1;
          emit_r.target    = 4'd0;
        end
      end
      B_QRY: begin
        if (c_qry && ak[ptr]) begin
          emit = 1'b1;
          emit_r.action = ACT_QUERY;
        end
      end
      B_SIL: begin
        if (c_sil) begin
          emit = 1'b1;
          emit_r.event_res = EV_SILENT;
        end
      end
      B_PUL: begin
        if (c_pul) begin
          emit = 1'b1;
          emit_r.event_res = EV_PULSE_END;
        end
      end
      B_CMP: begin
        if (c_mis) begin
          if (c_live) begin
            if (ls[ptr] != '0) begin
              emit = 1'b1;
              emit_r.action      = ACT_RELAY;
              emit_r.drive_state = cs[ptr];
              emit_r.event_res   = EV_RETRY;
            end
          end else if (cd[ptr] != '0) begin
            emit = 1'b1;
            emit_r.event_res = EV_TIMEOUT;
          end
        end
      end
      B_SET: begin
        if (ls[ptr] != '0) begin
          emit = 1'b1;
          emit_r.action      = ACT_RELAY;
          emit_r.drive_state = it.req_state;
        end
      end
      B_REP1: begin
        if (ls[ptr] == '0) begin
          emit = 1'b1;
          emit_r.event_res = EV_DETECTED;
        end
      end
      B_REP2: begin
        if (it.req_state != rs[ptr]) begin
          emit = 1'b1;
          emit_r.event_res = c_conf ? EV_CONFIRMED : EV_CHANGED;
        end
      end
      B_ACK: begin
        if (ak[ptr]) begin
          emit = 1'b1;
          emit_r.action = ACT_QUERY;
        end
      end
      B_UNK: begin
        emit = 1'b1;
        emit_r.target    = it.outlet;
        emit_r.event_res = EV_UNKNOWN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) begin
      it  <= q_item;
      ptr <= IW'(q_item.outlet);
    end else if (state == B_PASS) begin
      ptr <= '0;
    end else if (state == B_CMP && !c_lastp) begin
      ptr <= ptr + 1'b1;
    end
    if (emit) begin
      hold <= emit_r;
    end
    if (emit || (state == B_END && hold_v)) begin
      res <= hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      seconds_now <= '0;
      last_bc     <= '0;
      last_pass   <= '0;
      hold_v      <= 1'b0;
      res_valid   <= 1'b0;
      res_last    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        rs[i] <= 1'b0;
        cs[i] <= 1'b0;
        ak[i] <= 1'b0;
        cd[i] <= '0;
        pe[i] <= '0;
        lq[i] <= '0;
        ls[i] <= '0;
      end
    end else begin
      state <= state_next;

      // One result is held back so that the final one can carry last.
      res_valid <= 1'b0;
      res_last  <= 1'b0;
      if (emit) begin
        hold_v    <= 1'b1;
        res_valid <= hold_v;
      end else if (state == B_END && hold_v) begin
        hold_v    <= 1'b0;
        res_valid <= 1'b1;
        res_last  <= 1'b1;
      end

      unique case (state)
        B_TICK: begin
          seconds_now <= now1;
          if (c_bc) begin
            last_bc <= now1;
          end
        end
        B_PASS: begin
          if (c_pass) begin
            last_pass <= seconds_now;
          end
        end
        B_QRY: begin
          if (c_qry) begin
            lq[ptr] <= seconds_now;
          end
        end
        B_SIL: begin
          if (c_sil) begin
            rs[ptr] <= 1'b0;
            cs[ptr] <= 1'b0;
            cd[ptr] <= '0;
            pe[ptr] <= '0;
            ls[ptr] <= '0;
          end
        end
        B_PUL: begin
          if (c_pul) begin
            cs[ptr] <= 1'b0;
            cd[ptr] <= seconds_now + 32'(cfg.confirm_window);
            pe[ptr] <= '0;
          end
        end
        B_CMP: begin
          if (c_mis && !c_live) begin
            cs[ptr] <= rs[ptr];
            cd[ptr] <= '0;
            pe[ptr] <= '0;
          end
        end
        B_SET: begin
          pe[ptr] <= (it.pulse_seconds != '0) ?
                     seconds_now + 32'(it.pulse_seconds) : '0;
          cs[ptr] <= it.req_state;
          cd[ptr] <= seconds_now + 32'(cfg.confirm_window);
        end
        B_REP1: ak[ptr] <= 1'b1;
        B_REP2: begin
          if (it.req_state != rs[ptr]) begin
            if (!c_conf) begin
              cs[ptr] <= it.req_state;
            end
            cd[ptr] <= '0;
            rs[ptr] <= it.req_state;
          end
          ls[ptr] <= seconds_now;
        end
        B_ACK: begin
          if (ak[ptr]) begin
            lq[ptr] <= seconds_now;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/relay_command_supervisor_top.sv
// ----------------------------------------------------------------------------
// relay_command_supervisor_top
// Supervises a table of remote relay outlets and decides which packets to send.
// ----------------------------------------------------------------------------
// In the back end a set, acknowledgement or unknown-outlet request runs its own
// step, a status report its report steps, and a tick its tick and pass steps,
// then query, silence, pulse and compare steps for each active outlet when a
// supervision pass is due; every request ends in a final step. A result is
// held until the next one or the final step. The receiver cannot stall.
// Reset is synchronous, clears the clock and the table and sets the configuration registers to their defaults.
module relay_command_supervisor_top #(
  parameter int OUTLET_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [3:0]  outlet,
  input  logic        req_state,
  input  logic [15:0] pulse_seconds,
  input  logic        ack_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  action,
  output logic        broadcast,
  output logic [3:0]  target,
  output logic        drive_state,
  output logic [3:0]  event_res,
  output logic        last
);
  import rcs_pkg::*;

  // Configuration registers. Writes are taken at any time; the host is to write only
  // while no request is in flight, which the block itself does not enforce.
  logic [4:0]  outlet_count;
  logic [7:0]  retry_period, confirm_window;
  logic [15:0] query_period, broadcast_period, silence_limit;
  cfg_t        cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      outlet_count     <= 5'd0;
      retry_period     <= 8'd5;
      confirm_window   <= 8'd5;
      query_period     <= 16'd35;
      broadcast_period <= 16'd60;
      silence_limit    <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OUTLET_COUNT:     outlet_count     <= cfg_data[4:0];
        REG_RETRY_PERIOD:     retry_period     <= cfg_data[7:0];
        REG_CONFIRM_WINDOW:   confirm_window   <= cfg_data[7:0];
        REG_QUERY_PERIOD:     query_period     <= cfg_data;
        REG_BROADCAST_PERIOD: broadcast_period <= cfg_data;
        REG_SILENCE_LIMIT:    silence_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count above the table size is clamped to the table size.
  always_comb begin
    cfg.active = (outlet_count < 5'(OUTLET_SLOTS)) ? outlet_count : 5'(OUTLET_SLOTS);
    cfg.retry_period     = retry_period;
    cfg.confirm_window   = confirm_window;
    cfg.query_period     = query_period;
    cfg.broadcast_period = broadcast_period;
    cfg.silence_limit    = silence_limit;
  end

  // The front end classifies each request as it is accepted; the queue lets
  // new requests arrive while the back end is still walking the table.
  logic    push, pop, q_empty, q_full;
  item_t   f_item, q_item;
  result_t res;

  rcs_front u_front (
    .start         (start),
    .opcode        (opcode),
    .outlet        (outlet),
    .req_state     (req_state),
    .pulse_seconds (pulse_seconds),
    .ack_error     (ack_error),
    .active        (cfg.active),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .item          (f_item)
  );

  rcs_queue #(.DEPTH(2)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (f_item),
    .pop     (pop),
    .rd_item (q_item),
    .empty   (q_empty),
    .full    (q_full)
  );

  // The back end holds the outlet table and emits at most one result per
  // cycle; the last result of each request, if it has any, is flagged as it leaves.
  rcs_back #(.SLOTS(OUTLET_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .pop       (pop),
    .res_valid (result_valid),
    .res       (res),
    .res_last  (last)
  );

  assign action      = res.action;
  assign broadcast   = res.broadcast;
  assign target      = res.target;
  assign drive_state = res.drive_state;
  assign event_res   = res.event_res;

  // The last flag only travels with a result.
  a_last_with_result: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !last)
    else $error("last flag without a result");

  // Every result either sends something or reports an event.
  a_result_meaningful: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(action == ACT_NONE && event_res == EV_NONE))
    else $error("empty result");

  // A broadcast is always a status query addressed to outlet zero.
  a_broadcast_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && broadcast) |-> (action == ACT_QUERY && target == 4'd0))
    else $error("malformed broadcast");

endmodule
